/* design/cabr_pkg.sv */
// ---------------------------------------------------------------------------
// cabr_pkg: shared types, codes and helpers for the row aberration fix
// Pixel and item structs, configuration struct, register indexes, the
// engine state encoding and the per-channel gradient and clamp functions.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cabr_pkg;

    // Configuration register indexes
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_RADIUS    = 1'b1;

    // Depth of the queue between front and back
    localparam int QDEPTH = 4;

    typedef struct packed {
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
    } pixel_t;

    typedef struct packed {
        pixel_t pix;
        logic   last;
    } item_t;

    typedef struct packed {
        logic [15:0] threshold;
        logic [4:0]  radius;
    } cabr_cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SCAN,
        ST_E_RA,
        ST_E_RB,
        ST_E_CHK,
        ST_L_TEST,
        ST_L_RB,
        ST_L_CMP,
        ST_R_TEST,
        ST_R_RB,
        ST_R_CMP,
        ST_B_RA,
        ST_B_RB,
        ST_B_CMP,
        ST_C_TEST,
        ST_C_WR,
        ST_EM_RA,
        ST_EM_WAIT,
        ST_FL_RA,
        ST_FL_WAIT
    } eng_state_t;

    // True when the signed gradient of one channel reaches the threshold
    function automatic logic chan_ok(logic [15:0] a_prev, logic [15:0] a_next,
                                     logic neg, logic [15:0] thr);
        logic signed [17:0] d;
        d = signed'({2'b00, a_next}) - signed'({2'b00, a_prev});
        if (neg)
        begin
            d = -d;
        end
        return d >= signed'({2'b00, thr});
    endfunction

    // True when the largest of the three gradients is at or above the threshold
    function automatic logic grad_ok(pixel_t prv, pixel_t nxt, logic neg,
                                     logic [15:0] thr);
        return chan_ok(prv.g, nxt.g, neg, thr) | chan_ok(prv.b, nxt.b, neg, thr)
             | chan_ok(prv.r, nxt.r, neg, thr);
    endfunction

    function automatic logic [15:0] sat16(logic signed [17:0] v);
        logic [15:0] res;
        if (v < 0)
        begin
            res = 16'h0000;
        end
        else if (v > 18'sd65535)
        begin
            res = 16'hFFFF;
        end
        else
        begin
            res = v[15:0];
        end
        return res;
    endfunction

    // Keep the color difference c-g within dmin..dmax
    function automatic logic [15:0] clamp_chan(logic [15:0] c, logic [15:0] g,
                                               logic signed [17:0] dmax,
                                               logic signed [17:0] dmin);
        logic signed [17:0] gd;
        logic signed [17:0] dd;
        logic [15:0]        res;
        gd = signed'({2'b00, g});
        dd = signed'({2'b00, c}) - gd;
        if (dd > dmax)
        begin
            res = sat16(dmax + gd);
        end
        else if (dd < dmin)
        begin
            res = sat16(dmin + gd);
        end
        else
        begin
            res = c;
        end
        return res;
    endfunction

    function automatic logic signed [17:0] cdiff(logic [15:0] c, logic [15:0] g);
        return signed'({2'b00, c}) - signed'({2'b00, g});
    endfunction

endpackage

`default_nettype wire

/* design/cabr_ifs.sv */
// ---------------------------------------------------------------------------
// cabr_ifs: pixel channels of the row aberration fix
// Input channel carries raw pixels, output channel carries corrected ones.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cabr_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
    logic        last_in_row;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output last_in_row, input ready);
    modport sink (input valid, input red_in, input green_in, input blue_in,
                  input last_in_row, output ready);
endinterface

interface cabr_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic        row_end;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output row_end, input ready);
    modport sink (input valid, input red_out, input green_out, input blue_out,
                  input row_end, output ready);
endinterface

`default_nettype wire

/* design/cabr_queue.sv */
// ---------------------------------------------------------------------------
// cabr_queue: front end of the row aberration fix
// Accepts pixel requests, tags them with their row-end class and holds
// them in a short queue so the engine can stall on its own.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cabr_queue
    import cabr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    cabr_in_if.sink    pix_in,
    output logic       q_valid,
    output item_t      q_item,
    input  wire logic  q_pop
);

    localparam int QAW = $clog2(QDEPTH);

    item_t            slot_reg [QDEPTH];
    logic [QAW-1:0]   wptr_reg;
    logic [QAW-1:0]   rptr_reg;
    logic [QAW:0]     count_reg;
    logic             push;
    logic             pop;

    assign pix_in.ready = (count_reg < (QAW+1)'(QDEPTH));
    assign push         = pix_in.valid & pix_in.ready;
    assign pop          = q_pop & q_valid;
    assign q_valid      = (count_reg != '0);
    assign q_item       = slot_reg[rptr_reg];

    // Store the request with its class
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= '{pix: '{r: pix_in.red_in, g: pix_in.green_in,
                                           b: pix_in.blue_in},
                                    last: pix_in.last_in_row};
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == QAW'(QDEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == QAW'(QDEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* design/cabr_engine.sv */
// ---------------------------------------------------------------------------
// cabr_engine: back end of the row aberration fix
// Keeps the pixel window in a circular memory, runs the edge search and
// color difference clamp as a sequencer, and emits finished pixels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cabr_engine
    import cabr_pkg::*;
#(
    parameter int WINDOW     = 64,
    parameter int MAX_RADIUS = 30
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cabr_cfg_t  cfg,
    input  wire logic       q_valid,
    input  wire item_t      q_item,
    output logic            q_pop,
    cabr_out_if.source      pix_out
);

    localparam int AW    = $clog2(WINDOW);
    localparam int CW    = $clog2(WINDOW + 1);
    localparam int PW    = CW + 2;
    localparam int CAP_R = (2 * MAX_RADIUS + 4 <= WINDOW) ? MAX_RADIUS : (WINDOW - 4) / 2;

    typedef logic signed [PW-1:0] pos_t;

    eng_state_t         state_reg;
    eng_state_t         state_next;

    pixel_t             mem [WINDOW];
    pixel_t             rd_data_reg;
    logic               rd_en;
    pos_t               rd_pos;
    logic               wr_en;
    pos_t               wr_pos;
    pixel_t             wr_data;

    logic [AW-1:0]      base_reg;
    logic [CW-1:0]      held_reg;
    logic [CW-1:0]      rowpos_reg;
    pos_t               scan_reg;
    logic               last_reg;
    pos_t               x_reg;
    pos_t               l_reg;
    pos_t               r_reg;
    pos_t               k_reg;
    logic               neg_reg;
    pixel_t             pa_reg;
    logic signed [17:0] bmax_reg;
    logic signed [17:0] bmin_reg;
    logic signed [17:0] rmax_reg;
    logic signed [17:0] rmin_reg;

    logic               out_valid_reg;
    pixel_t             out_pix_reg;
    logic               out_end_reg;
    logic               out_free;

    pos_t               held_pos;
    pos_t               hi_pos;
    pos_t               lo_pos;
    pos_t               rad_ext;
    pos_t               rad_pos;
    logic               scan_go;
    logic signed [17:0] d_edge;
    logic signed [17:0] d_abs;
    logic               edge_hit;
    logic               grad_cont;
    logic               l_go;
    logic               r_go;
    logic               fl_last;
    pixel_t             clamp_pix;
    logic signed [17:0] bl;
    logic signed [17:0] br;
    logic signed [17:0] rl;
    logic signed [17:0] rr;

    // Map a window position to its memory slot
    function automatic logic [AW-1:0] slot_of(logic [AW-1:0] base, pos_t pos);
        logic [AW:0] s;
        s = {1'b0, base} + {1'b0, pos[AW-1:0]};
        if (s >= (AW+1)'(WINDOW))
        begin
            s = s - (AW+1)'(WINDOW);
        end
        return s[AW-1:0];
    endfunction

    // Window bounds and scan decisions
    assign held_pos  = pos_t'({2'b00, held_reg});
    assign hi_pos    = held_pos - pos_t'(2);
    assign lo_pos    = (rowpos_reg > held_reg) ? pos_t'(0) : pos_t'(1);
    assign rad_ext   = pos_t'(cfg.radius);
    assign rad_pos   = (rad_ext > pos_t'(CAP_R)) ? pos_t'(CAP_R) : rad_ext;
    assign scan_go   = last_reg ? ((scan_reg >= pos_t'(1)) && (scan_reg < hi_pos))
                                : ((scan_reg >= pos_t'(1)) &&
                                   (scan_reg + pos_t'(CAP_R + 3) <= held_pos));
    assign d_edge    = cdiff(rd_data_reg.g, pa_reg.g);
    assign d_abs     = (d_edge < 0) ? -d_edge : d_edge;
    assign edge_hit  = (d_abs >= signed'({2'b00, cfg.threshold}));
    assign grad_cont = grad_ok(pa_reg, rd_data_reg, neg_reg, cfg.threshold);
    assign l_go      = (l_reg > lo_pos) && ((x_reg - l_reg) < rad_pos);
    assign r_go      = (r_reg < hi_pos) && ((r_reg - x_reg) < rad_pos);
    assign fl_last   = (k_reg == held_pos - pos_t'(1));
    assign out_free  = !out_valid_reg || pix_out.ready;

    // Range end differences
    assign bl = cdiff(pa_reg.b, pa_reg.g);
    assign rl = cdiff(pa_reg.r, pa_reg.g);
    assign br = cdiff(rd_data_reg.b, rd_data_reg.g);
    assign rr = cdiff(rd_data_reg.r, rd_data_reg.g);

    // Clamp one pixel inside the range
    always_comb
    begin
        clamp_pix.g = rd_data_reg.g;
        clamp_pix.b = clamp_chan(rd_data_reg.b, rd_data_reg.g, bmax_reg, bmin_reg);
        clamp_pix.r = clamp_chan(rd_data_reg.r, rd_data_reg.g, rmax_reg, rmin_reg);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                priority if (scan_go)
                begin
                    state_next = ST_E_RA;
                end
                else if (last_reg)
                begin
                    state_next = ST_FL_RA;
                end
                else if (held_pos == pos_t'(WINDOW))
                begin
                    state_next = ST_EM_RA;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_E_RA:    state_next = ST_E_RB;
            ST_E_RB:    state_next = ST_E_CHK;
            ST_E_CHK:   state_next = edge_hit ? ST_L_TEST : ST_SCAN;
            ST_L_TEST:  state_next = l_go ? ST_L_RB : ST_R_TEST;
            ST_L_RB:    state_next = ST_L_CMP;
            ST_L_CMP:   state_next = grad_cont ? ST_L_TEST : ST_R_TEST;
            ST_R_TEST:  state_next = r_go ? ST_R_RB : ST_B_RA;
            ST_R_RB:    state_next = ST_R_CMP;
            ST_R_CMP:   state_next = grad_cont ? ST_R_TEST : ST_B_RA;
            ST_B_RA:    state_next = ST_B_RB;
            ST_B_RB:    state_next = ST_B_CMP;
            ST_B_CMP:   state_next = ST_C_TEST;
            ST_C_TEST:
            begin
                priority if (k_reg > r_reg)
                begin
                    state_next = ST_SCAN;
                end
                else if (k_reg < 0)
                begin
                    state_next = ST_C_TEST;
                end
                else
                begin
                    state_next = ST_C_WR;
                end
            end
            ST_C_WR:    state_next = ST_C_TEST;
            ST_EM_RA:   state_next = ST_EM_WAIT;
            ST_EM_WAIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FL_RA:   state_next = ST_FL_WAIT;
            ST_FL_WAIT:
            begin
                if (out_free)
                begin
                    state_next = fl_last ? ST_IDLE : ST_FL_RA;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Memory port controls per state
    always_comb
    begin
        rd_en   = 1'b0;
        rd_pos  = '0;
        wr_en   = 1'b0;
        wr_pos  = '0;
        wr_data = clamp_pix;
        q_pop   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                q_pop   = q_valid;
                wr_en   = q_valid;
                wr_pos  = held_pos;
                wr_data = q_item.pix;
            end
            ST_E_RA:
            begin
                rd_en  = 1'b1;
                rd_pos = x_reg - pos_t'(1);
            end
            ST_E_RB:
            begin
                rd_en  = 1'b1;
                rd_pos = x_reg + pos_t'(1);
            end
            ST_L_TEST:
            begin
                rd_en  = l_go;
                rd_pos = l_reg - pos_t'(1);
            end
            ST_L_RB:
            begin
                rd_en  = 1'b1;
                rd_pos = l_reg + pos_t'(1);
            end
            ST_R_TEST:
            begin
                rd_en  = r_go;
                rd_pos = r_reg - pos_t'(1);
            end
            ST_R_RB:
            begin
                rd_en  = 1'b1;
                rd_pos = r_reg + pos_t'(1);
            end
            ST_B_RA:
            begin
                rd_en  = 1'b1;
                rd_pos = l_reg;
            end
            ST_B_RB:
            begin
                rd_en  = 1'b1;
                rd_pos = r_reg;
            end
            ST_C_TEST:
            begin
                rd_en  = (k_reg <= r_reg) && (k_reg >= 0);
                rd_pos = k_reg;
            end
            ST_C_WR:
            begin
                wr_en  = 1'b1;
                wr_pos = k_reg;
            end
            ST_EM_RA:
            begin
                rd_en  = 1'b1;
                rd_pos = '0;
            end
            ST_FL_RA:
            begin
                rd_en  = 1'b1;
                rd_pos = k_reg;
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Window memory with registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[slot_of(base_reg, wr_pos)] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[slot_of(base_reg, rd_pos)];
        end
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Window bookkeeping and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            held_reg      <= '0;
            rowpos_reg    <= '0;
            scan_reg      <= pos_t'(2);
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pix_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        held_reg <= held_reg + 1'b1;
                        if (rowpos_reg < CW'(WINDOW))
                        begin
                            rowpos_reg <= rowpos_reg + 1'b1;
                        end
                        last_reg <= q_item.last;
                    end
                end
                ST_E_CHK:
                begin
                    if (!edge_hit)
                    begin
                        scan_reg <= x_reg + pos_t'(1);
                    end
                end
                ST_C_TEST:
                begin
                    if (k_reg > r_reg)
                    begin
                        scan_reg <= r_reg - pos_t'(1);
                    end
                end
                ST_EM_WAIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        base_reg      <= (base_reg == AW'(WINDOW - 1)) ? '0 : base_reg + 1'b1;
                        held_reg      <= held_reg - 1'b1;
                        if (scan_reg > pos_t'(1))
                        begin
                            scan_reg <= scan_reg - pos_t'(1);
                        end
                    end
                end
                ST_FL_WAIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (fl_last)
                        begin
                            held_reg   <= '0;
                            rowpos_reg <= '0;
                            scan_reg   <= pos_t'(2);
                        end
                    end
                end
                default:
                begin
                    base_reg <= base_reg;
                end
            endcase
        end
    end

    // Edge datapath and output payload
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_SCAN:
            begin
                x_reg <= scan_reg;
                k_reg <= '0;
            end
            ST_E_RB:
            begin
                pa_reg <= rd_data_reg;
            end
            ST_E_CHK:
            begin
                neg_reg <= !(d_edge > 0);
                l_reg   <= x_reg - pos_t'(1);
            end
            ST_L_TEST:
            begin
                if (!l_go)
                begin
                    l_reg <= l_reg - pos_t'(1);
                    r_reg <= x_reg + pos_t'(1);
                end
            end
            ST_L_RB:
            begin
                pa_reg <= rd_data_reg;
            end
            ST_L_CMP:
            begin
                l_reg <= l_reg - pos_t'(1);
                if (!grad_cont)
                begin
                    r_reg <= x_reg + pos_t'(1);
                end
            end
            ST_R_TEST:
            begin
                if (!r_go)
                begin
                    r_reg <= r_reg + pos_t'(1);
                end
            end
            ST_R_RB:
            begin
                pa_reg <= rd_data_reg;
            end
            ST_R_CMP:
            begin
                r_reg <= r_reg + pos_t'(1);
            end
            ST_B_RB:
            begin
                // Left end beyond the row start reads as black
                pa_reg <= (l_reg < 0) ? pixel_t'('0) : rd_data_reg;
            end
            ST_B_CMP:
            begin
                bmax_reg <= (bl > br) ? bl : br;
                bmin_reg <= (bl < br) ? bl : br;
                rmax_reg <= (rl > rr) ? rl : rr;
                rmin_reg <= (rl < rr) ? rl : rr;
                k_reg    <= l_reg;
            end
            ST_C_TEST:
            begin
                if (k_reg < 0)
                begin
                    k_reg <= k_reg + pos_t'(1);
                end
            end
            ST_C_WR:
            begin
                k_reg <= k_reg + pos_t'(1);
            end
            ST_EM_WAIT:
            begin
                if (out_free)
                begin
                    out_pix_reg <= rd_data_reg;
                    out_end_reg <= 1'b0;
                end
            end
            ST_FL_WAIT:
            begin
                if (out_free)
                begin
                    out_pix_reg <= rd_data_reg;
                    out_end_reg <= fl_last;
                    k_reg       <= k_reg + pos_t'(1);
                end
            end
            default:
            begin
                out_end_reg <= out_end_reg;
            end
        endcase
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.red_out   = out_pix_reg.r;
    assign pix_out.green_out = out_pix_reg.g;
    assign pix_out.blue_out  = out_pix_reg.b;
    assign pix_out.row_end   = out_end_reg;

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CW'(WINDOW))
        else $error("window fill above capacity");

    a_idle_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> held_reg < CW'(WINDOW))
        else $error("no room for the next pixel");

    a_clamp_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_C_WR |-> (k_reg >= 0) && (k_reg < held_pos))
        else $error("clamp write outside held pixels");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FL_WAIT) && out_free && fl_last |=> held_reg == '0)
        else $error("row flush left pixels behind");
`endif

endmodule

`default_nettype wire

/* design/chroma_aberration_row_fix.sv */
// ---------------------------------------------------------------------------
// chroma_aberration_row_fix: horizontal chromatic aberration correction
// Clamps blue and red around green edges of one pixel row.
// ---------------------------------------------------------------------------
// Usage:
//   pix_in takes one RGB pixel per request, last_in_row on the final pixel
//   of a row. pix_out returns corrected pixels in order; green is passed
//   through, row_end marks the last pixel of the row.
//   cfg_we/cfg_index/cfg_data write threshold (index 0) and radius
//   (index 1) while the block is idle.
// Pixel flow:
//   A pixel leaves WINDOW-1 pixels after it arrives, or at row end when
//   the whole window is flushed one pixel at a time. Each pixel passes the
//   engine sequencer, which also spends steps on every edge candidate,
//   every range step, the clamp set-up and every clamped pixel, all on the
//   single read port of the window memory.
// Reset:
//   Clears the window fill, scan position and queue; threshold returns to
//   1311 and radius to 5. No clearing pass is needed.
// Stall:
//   A stalled receiver holds the output register; the engine then waits
//   and the four-entry input queue fills before pix_in drops ready.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module chroma_aberration_row_fix
    import cabr_pkg::*;
#(
    parameter int WINDOW     = 64,
    parameter int MAX_RADIUS = 30
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    cabr_in_if.sink          pix_in,
    cabr_out_if.source       pix_out,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [15:0] threshold_reg;
    logic [4:0]  radius_reg;
    cabr_cfg_t   cfg;
    logic        q_valid;
    item_t       q_item;
    logic        q_pop;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= 16'd1311;
            radius_reg    <= 5'd5;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESHOLD: threshold_reg <= cfg_data;
                REG_RADIUS:    radius_reg    <= cfg_data[4:0];
                default:       threshold_reg <= threshold_reg;
            endcase
        end
    end

    assign cfg = '{threshold: threshold_reg, radius: radius_reg};

    cabr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    cabr_engine #(
        .WINDOW     (WINDOW),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .pix_out (pix_out)
    );

endmodule

`default_nettype wire

/* tb/sv/tb_chroma_aberration_row_fix.sv */
// ---------------------------------------------------------------------------
// tb_chroma_aberration_row_fix: self-checking bench for the row aberration fix
// Streams rows of RGB pixels with random gaps and output stalls, predicts the
// corrected pixels with a behavioral copy of the edge/clamp algorithm and
// compares every returned pixel in order. Threshold and radius are changed
// between rows while the block is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

class row_fix_scoreboard;
    localparam int WIN   = 64;
    localparam int MAXR  = 30;
    localparam int CAPR  = (2 * MAXR + 4 <= WIN) ? MAXR : (WIN - 4) / 2;

    logic [15:0] win_px[WIN][3];
    int          held;
    int          row_pos;
    int          scan_pos;
    logic [15:0] thr;
    logic [4:0]  rad_reg;
    logic [48:0] pending[$];
    int          errors;
    int          checked;

    function new();
        held = 0;
        row_pos = 0;
        scan_pos = 2;
        thr = 16'd1311;
        rad_reg = 5'd5;
        errors = 0;
        checked = 0;
        for (int i = 0; i < WIN; i++)
        begin
            win_px[i][0] = 0;
            win_px[i][1] = 0;
            win_px[i][2] = 0;
        end
    endfunction

    function int sample(int i, int c);
        if (i < 0 || i >= WIN)
        begin
            return 0;
        end
        return int'(win_px[i][c]);
    endfunction

    function logic [15:0] clip16(int v);
        if (v < 0)
        begin
            return 16'd0;
        end
        if (v > 65535)
        begin
            return 16'hFFFF;
        end
        return v[15:0];
    endfunction

    function int steepest(int p, int s);
        int m;
        int b;
        int r;
        m = (sample(p + 1, 1) - sample(p - 1, 1)) * s;
        b = (sample(p + 1, 2) - sample(p - 1, 2)) * s;
        r = (sample(p + 1, 0) - sample(p - 1, 0)) * s;
        if (b > m)
        begin
            m = b;
        end
        if (r > m)
        begin
            m = r;
        end
        return m;
    endfunction

    // Grow the range around edge x and clamp blue/red; return next candidate
    function int fix_edge(int x, int lo, int hi);
        int t;
        int rd;
        int d;
        int s;
        int l;
        int r;
        int bl, br, rl, rr, bmax, bmin, rmax, rmin;
        int g, bd, rdf;
        t = int'(thr);
        rd = int'(rad_reg);
        if (rd > MAXR)
        begin
            rd = MAXR;
        end
        if (rd > CAPR)
        begin
            rd = CAPR;
        end
        d = sample(x + 1, 1) - sample(x - 1, 1);
        if ((d < 0 ? -d : d) < t)
        begin
            return x + 1;
        end
        s = d > 0 ? 1 : -1;
        l = x - 1;
        while (l > lo)
        begin
            if (x - l >= rd || steepest(l, s) < t)
            begin
                break;
            end
            l--;
        end
        l--;
        r = x + 1;
        while (r < hi)
        begin
            if (r - x >= rd || steepest(r, s) < t)
            begin
                break;
            end
            r++;
        end
        r++;
        bl = sample(l, 2) - sample(l, 1);
        br = sample(r, 2) - sample(r, 1);
        rl = sample(l, 0) - sample(l, 1);
        rr = sample(r, 0) - sample(r, 1);
        bmax = bl > br ? bl : br;
        bmin = bl < br ? bl : br;
        rmax = rl > rr ? rl : rr;
        rmin = rl < rr ? rl : rr;
        for (int k = l; k <= r; k++)
        begin
            if (k < 0 || k >= WIN)
            begin
                continue;
            end
            g = sample(k, 1);
            bd = sample(k, 2) - g;
            rdf = sample(k, 0) - g;
            if (bd > bmax)
            begin
                win_px[k][2] = clip16(bmax + g);
            end
            else if (bd < bmin)
            begin
                win_px[k][2] = clip16(bmin + g);
            end
            if (rdf > rmax)
            begin
                win_px[k][0] = clip16(rmax + g);
            end
            else if (rdf < rmin)
            begin
                win_px[k][0] = clip16(rmin + g);
            end
        end
        return r - 1;
    endfunction

    function void emit(int i, bit last);
        pending.push_back({win_px[i][0], win_px[i][1], win_px[i][2], last});
    endfunction

    function void set_reg(logic idx, logic [15:0] val);
        if (idx == cabr_pkg::REG_THRESHOLD)
        begin
            thr = val;
        end
        else
        begin
            rad_reg = val[4:0];
        end
    endfunction

    // Note one accepted input pixel
    function void note_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b, logic last);
        int lo;
        int hi;
        if (held >= WIN)
        begin
            held = WIN - 1;
        end
        win_px[held][0] = r;
        win_px[held][1] = g;
        win_px[held][2] = b;
        held++;
        if (row_pos < WIN)
        begin
            row_pos++;
        end
        lo = (row_pos > held) ? 0 : 1;
        hi = held - 2;
        if (last)
        begin
            while (scan_pos >= 1 && scan_pos < hi)
            begin
                scan_pos = fix_edge(scan_pos, lo, hi);
            end
            for (int i = 0; i < held; i++)
            begin
                emit(i, i == held - 1);
            end
            held = 0;
            row_pos = 0;
            scan_pos = 2;
            return;
        end
        while (scan_pos >= 1 && scan_pos + CAPR + 3 <= held)
        begin
            scan_pos = fix_edge(scan_pos, lo, hi);
        end
        if (held == WIN)
        begin
            emit(0, 1'b0);
            for (int i = 0; i < WIN - 1; i++)
            begin
                win_px[i] = win_px[i + 1];
            end
            held--;
            if (scan_pos > 1)
            begin
                scan_pos--;
            end
        end
    endfunction

    // Compare one returned pixel with the oldest expected one
    function void check_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b, logic e);
        logic [48:0] exp_px;
        checked++;
        if (pending.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected pixel r=%h g=%h b=%h end=%b", $time, r, g, b, e);
            return;
        end
        exp_px = pending.pop_front();
        if (exp_px[48:33] !== r)
        begin
            errors++;
            $display("%0t: red expected %h actual %h", $time, exp_px[48:33], r);
        end
        if (exp_px[32:17] !== g)
        begin
            errors++;
            $display("%0t: green expected %h actual %h", $time, exp_px[32:17], g);
        end
        if (exp_px[16:1] !== b)
        begin
            errors++;
            $display("%0t: blue expected %h actual %h", $time, exp_px[16:1], b);
        end
        if (exp_px[0] !== e)
        begin
            errors++;
            $display("%0t: row_end expected %b actual %b", $time, exp_px[0], e);
        end
    endfunction
endclass

module tb_chroma_aberration_row_fix;
    import cabr_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    bit          calm;
    int          pixels_sent;
    int          rows_sent;

    cabr_in_if  pix_in ();
    cabr_out_if pix_out ();

    row_fix_scoreboard sb;

    chroma_aberration_row_fix uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix_in   (pix_in.sink),
        .pix_out  (pix_out.source),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    // Stall the output side at random, except during the calm stretch
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            pix_out.ready <= calm || ($urandom_range(0, 99) >= 10);
            if (pix_out.valid && pix_out.ready)
            begin
                sb.check_pixel(pix_out.red_out, pix_out.green_out, pix_out.blue_out,
                               pix_out.row_end);
            end
        end
    end

    task automatic write_reg(logic idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // Offer one pixel, with an optional random gap, and hold until accepted
    task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b, logic last);
        while (!calm && $urandom_range(0, 99) < 10)
        begin
            pix_in.valid <= 1'b0;
            @(posedge clk);
        end
        pix_in.valid       <= 1'b1;
        pix_in.red_in      <= r;
        pix_in.green_in    <= g;
        pix_in.blue_in     <= b;
        pix_in.last_in_row <= last;
        @(posedge clk);
        while (!pix_in.ready)
        begin
            @(posedge clk);
        end
        sb.note_pixel(r, g, b, last);
        pixels_sent++;
        if (last)
        begin
            rows_sent++;
        end
    endtask

    task automatic release_input();
        pix_in.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until every expected pixel is back, then let the engine settle
    task automatic drain();
        int guard;
        guard = 0;
        while (sb.pending.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (200) @(posedge clk);
    endtask

    function automatic logic [15:0] clip_add(logic [15:0] a, int d);
        int v;
        v = int'(a) + d;
        return v < 0 ? 16'd0 : (v > 65535 ? 16'hFFFF : v[15:0]);
    endfunction

    // Random row: mode 0 sends random pixels, other modes smooth ramps with sharp green steps and fringed colors
    task automatic send_row(int len, int mode);
        logic [15:0] g;
        logic [15:0] r;
        logic [15:0] b;
        int          step;
        g = 16'($urandom);
        for (int i = 0; i < len; i++)
        begin
            if (mode == 0)
            begin
                r = 16'($urandom);
                g = 16'($urandom);
                b = 16'($urandom);
            end
            else
            begin
                step = $urandom_range(0, 9) < 2 ? int'($urandom_range(0, 30000))
                                                : int'($urandom_range(0, 800));
                if ($urandom_range(0, 1) == 1)
                begin
                    g = clip_add(g, step);
                end
                else
                begin
                    g = clip_add(g, -step);
                end
                r = clip_add(g, int'($urandom_range(0, 12000)) - 6000);
                b = clip_add(g, int'($urandom_range(0, 12000)) - 6000);
            end
            send_pixel(r, g, b, i == len - 1);
        end
        release_input();
    endtask

    initial
    begin
        int len;
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_THRESHOLD;
        cfg_data = 16'd0;
        calm = 1'b0;
        pixels_sent = 0;
        rows_sent = 0;
        pix_in.valid = 1'b0;
        pix_in.red_in = 16'd0;
        pix_in.green_in = 16'd0;
        pix_in.blue_in = 16'd0;
        pix_in.last_in_row = 1'b0;
        pix_out.ready = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single pixel, short row, extremes, a hard edge
        send_pixel(16'hFFFF, 16'h0000, 16'hFFFF, 1'b1);
        send_pixel(16'h0000, 16'hFFFF, 16'h0000, 1'b0);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_pixel(16'h1234, 16'h0000, 16'hABCD, 1'b1);
        for (int i = 0; i < 12; i++)
        begin
            send_pixel(i < 6 ? 16'hFFFF : 16'h0000, i < 6 ? 16'h0000 : 16'hFFFF,
                       i[0] ? 16'h5555 : 16'hAAAA, i == 11);
        end
        release_input();
        drain();

        // Radius zero and full radius, threshold extremes
        write_reg(REG_RADIUS, 16'd0);
        write_reg(REG_THRESHOLD, 16'd0);
        send_row(8, 1);
        drain();
        write_reg(REG_RADIUS, 16'd31);
        write_reg(REG_THRESHOLD, 16'hFFFF);
        send_row(6, 0);
        drain();

        // Random rows over several settings; one calm stretch in the middle
        while (pixels_sent < 260)
        begin
            case ($urandom_range(0, 3))
                0: write_reg(REG_THRESHOLD, 16'($urandom_range(0, 4000)));
                1: write_reg(REG_RADIUS, 16'($urandom_range(0, 31)));
                2: write_reg(REG_THRESHOLD, 16'($urandom));
                default: write_reg(REG_RADIUS, 16'd30);
            endcase
            calm = (pixels_sent >= 110) && (pixels_sent < 180);
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 90) : $urandom_range(1, 24);
            if (rows_sent == 5)
            begin
                len = 80;
            end
            if (len > 260 - pixels_sent)
            begin
                len = 260 - pixels_sent;
            end
            send_row(len, $urandom_range(0, 4) == 0 ? 0 : 1);
            drain();
        end
        calm = 1'b0;
        write_reg(REG_THRESHOLD, 16'd1311);
        write_reg(REG_RADIUS, 16'd5);
        send_row(20, 1);
        drain();

        $display("tb: sent %0d pixels in %0d rows, checked %0d output pixels",
                 pixels_sent, rows_sent, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

/* files.f */
design/cabr_pkg.sv
design/cabr_ifs.sv
design/cabr_queue.sv
design/cabr_engine.sv
design/chroma_aberration_row_fix.sv
tb/sv/tb_chroma_aberration_row_fix.sv
